>>> rtl/lhsm_pkg.sv
// ----------------------------------------------------------------------------
// lhsm_pkg
// Shared types and constants for the leader health supervisor.
// ----------------------------------------------------------------------------
package lhsm_pkg;

	localparam int unsigned NOW_W    = 48;
	localparam int unsigned TERM_W   = 32;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned GRACE_W  = 32;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// s_axis_tdata: now_ms, term, spaces_failures, session_failures, monitor_stalled
	localparam int unsigned IN_BITS   = NOW_W + TERM_W + 2 * CNT_W + 1;
	localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// m_axis_tdata: health_state, reason_code, since_ms, term_out, four flags
	localparam int unsigned ST_W      = 3;
	localparam int unsigned RS_W      = 4;
	localparam int unsigned OUT_BITS  = ST_W + RS_W + NOW_W + TERM_W + 4;
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_FOLLOWER = 2'd0,
		CMD_GRACE    = 2'd1,
		CMD_PROBE    = 2'd2
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_FOLLOWER  = 3'd0,
		ST_GRACE     = 3'd1,
		ST_HEALTHY   = 3'd2,
		ST_SUSPECT   = 3'd3,
		ST_UNHEALTHY = 3'd4
	} hstate_t;

	typedef enum logic [RS_W-1:0] {
		RS_FOLLOWER   = 4'd0,
		RS_GRACE      = 4'd1,
		RS_LATCHED    = 4'd2,
		RS_STALLED    = 4'd3,
		RS_PROBE1     = 4'd4,
		RS_PROBE2     = 4'd5,
		RS_PARTIAL    = 4'd6,
		RS_RECOVERING = 4'd7,
		RS_PASSED     = 4'd8
	} reason_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAIL_THRESHOLD    = 2'd0,
		CFG_RECOVER_SUCCESSES = 2'd1,
		CFG_GRACE_MS          = 2'd2
	} cfg_idx_t;

	// Effective thresholds, zero already mapped to one
	typedef struct packed {
		logic [CNT_W-1:0]   fail_thr;
		logic [CNT_W-1:0]   suspect_thr;
		logic [CNT_W-1:0]   recover_thr;
		logic [GRACE_W-1:0] grace_ms;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [NOW_W-1:0]  now_ms;
		logic [TERM_W-1:0] term;
		logic [CNT_W-1:0]  spaces_failures;
		logic [CNT_W-1:0]  session_failures;
		logic              monitor_stalled;
	} item_t;

	localparam logic [CNT_W-1:0] FAIL_THR_RST    = 8'd3;
	localparam logic [CNT_W-1:0] RECOVER_THR_RST = 8'd3;
	localparam logic [GRACE_W-1:0] GRACE_MS_RST  = 32'd30000;
	localparam logic [CNT_W-1:0] CNT_ONE = 8'd1;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

endpackage

>>> rtl/lhsm_cfg.sv
// ----------------------------------------------------------------------------
// lhsm_cfg
// Configuration registers; thresholds stored in their effective form.
// ----------------------------------------------------------------------------
module lhsm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lhsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lhsm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output lhsm_pkg::cfg_t                     cfg
);

	logic [lhsm_pkg::CNT_W-1:0] wr_cnt;
	logic [lhsm_pkg::CNT_W-1:0] wr_eff;
	logic [lhsm_pkg::CNT_W-1:0] wr_half;

	assign wr_cnt  = cfg_data[lhsm_pkg::CNT_W-1:0];
	// zero acts as one
	assign wr_eff  = (wr_cnt == '0) ? lhsm_pkg::CNT_ONE : wr_cnt;
	assign wr_half = (wr_eff >> 1) == '0 ? lhsm_pkg::CNT_ONE : (wr_eff >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.fail_thr    <= lhsm_pkg::FAIL_THR_RST;
			cfg.suspect_thr <= lhsm_pkg::FAIL_THR_RST >> 1;
			cfg.recover_thr <= lhsm_pkg::RECOVER_THR_RST;
			cfg.grace_ms    <= lhsm_pkg::GRACE_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lhsm_pkg::CFG_FAIL_THRESHOLD: begin
					cfg.fail_thr    <= wr_eff;
					cfg.suspect_thr <= wr_half;
				end
				lhsm_pkg::CFG_RECOVER_SUCCESSES: begin
					cfg.recover_thr <= wr_eff;
				end
				lhsm_pkg::CFG_GRACE_MS: begin
					cfg.grace_ms <= cfg_data[lhsm_pkg::GRACE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/lhsm_in_stage.sv
// ----------------------------------------------------------------------------
// lhsm_in_stage
// Input register: unpacks and holds one item for the update stage.
// ----------------------------------------------------------------------------
module lhsm_in_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [lhsm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic [lhsm_pkg::CMD_W-1:0]          s_axis_tuser,
	input  logic                                adv,
	output logic                                valid_s1,
	output lhsm_pkg::item_t                     item_s1
);

	logic take;

	assign s_axis_tready = !valid_s1 || adv;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.command          <= s_axis_tuser;
			item_s1.now_ms           <= s_axis_tdata[47:0];
			item_s1.term             <= s_axis_tdata[79:48];
			item_s1.spaces_failures  <= s_axis_tdata[87:80];
			item_s1.session_failures <= s_axis_tdata[95:88];
			item_s1.monitor_stalled  <= s_axis_tdata[96];
		end
	end

endmodule

>>> rtl/lhsm_core.sv
// ----------------------------------------------------------------------------
// lhsm_core
// Supervisor state, next-state logic and the result register.
// ----------------------------------------------------------------------------
module lhsm_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lhsm_pkg::cfg_t                      cfg,
	input  logic                                valid_s1,
	input  lhsm_pkg::item_t                     item_s1,
	output logic                                adv,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [lhsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	lhsm_pkg::hstate_t            state_q, state_n;
	lhsm_pkg::reason_t            reason_q, reason_n;
	logic [lhsm_pkg::NOW_W-1:0]   since_q, since_n;
	logic [lhsm_pkg::TERM_W-1:0]  term_q, term_n;
	logic                         leader_q, leader_n;
	logic                         latch_q, latch_n;
	logic                         gmark_q, gmark_n;
	logic [lhsm_pkg::CNT_W-1:0]   streak_q, streak_n, streak_inc;
	logic [lhsm_pkg::NOW_W:0]     elapsed;
	logic                         open_n;
	logic                         upd;

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign upd = valid_s1 && adv;

	assign streak_inc = (streak_q == lhsm_pkg::CNT_MAX) ? streak_q : streak_q + 8'd1;

	always_comb begin
		state_n  = state_q;
		reason_n = reason_q;
		term_n   = term_q;
		leader_n = leader_q;
		latch_n  = latch_q;
		gmark_n  = gmark_q;
		streak_n = streak_q;
		case (item_s1.command)
			lhsm_pkg::CMD_FOLLOWER, lhsm_pkg::CMD_GRACE: begin
				leader_n = item_s1.command[0];
				gmark_n  = item_s1.command[0];
				term_n   = item_s1.term;
				latch_n  = 1'b0;
				streak_n = '0;
				state_n  = item_s1.command[0] ? lhsm_pkg::ST_GRACE : lhsm_pkg::ST_FOLLOWER;
				reason_n = item_s1.command[0] ? lhsm_pkg::RS_GRACE : lhsm_pkg::RS_FOLLOWER;
			end
			lhsm_pkg::CMD_PROBE: begin
				term_n   = item_s1.term;
				leader_n = 1'b1;
				gmark_n  = 1'b0;
				if (latch_q) begin
					state_n  = lhsm_pkg::ST_UNHEALTHY;
					reason_n = lhsm_pkg::RS_LATCHED;
				end else if (item_s1.monitor_stalled) begin
					latch_n  = 1'b1;
					state_n  = lhsm_pkg::ST_UNHEALTHY;
					reason_n = lhsm_pkg::RS_STALLED;
				end else if (item_s1.spaces_failures >= cfg.fail_thr) begin
					latch_n  = 1'b1;
					state_n  = lhsm_pkg::ST_UNHEALTHY;
					reason_n = lhsm_pkg::RS_PROBE1;
				end else if (item_s1.session_failures >= cfg.fail_thr) begin
					latch_n  = 1'b1;
					state_n  = lhsm_pkg::ST_UNHEALTHY;
					reason_n = lhsm_pkg::RS_PROBE2;
				end else if (item_s1.spaces_failures >= cfg.suspect_thr ||
						item_s1.session_failures >= cfg.suspect_thr) begin
					streak_n = '0;
					state_n  = lhsm_pkg::ST_SUSPECT;
					reason_n = lhsm_pkg::RS_PARTIAL;
				end else begin
					streak_n = streak_inc;
					if (state_q == lhsm_pkg::ST_SUSPECT && streak_inc < cfg.recover_thr) begin
						state_n  = lhsm_pkg::ST_SUSPECT;
						reason_n = lhsm_pkg::RS_RECOVERING;
					end else begin
						state_n  = lhsm_pkg::ST_HEALTHY;
						reason_n = lhsm_pkg::RS_PASSED;
					end
				end
			end
			default: begin
				// unknown command: state held
			end
		endcase
	end

	// since only moves on an actual state change
	assign since_n = (state_n != state_q) ? item_s1.now_ms : since_q;

	// borrow out of the top bit means now is before entry: window still open
	assign elapsed = {1'b0, item_s1.now_ms} - {1'b0, since_n};
	assign open_n  = (state_n == lhsm_pkg::ST_GRACE) &&
		(elapsed[lhsm_pkg::NOW_W] ||
		 elapsed[lhsm_pkg::NOW_W-1:0] < {16'd0, cfg.grace_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lhsm_pkg::ST_FOLLOWER;
			reason_q      <= lhsm_pkg::RS_FOLLOWER;
			since_q       <= '0;
			term_q        <= '0;
			leader_q      <= 1'b0;
			latch_q       <= 1'b0;
			gmark_q       <= 1'b0;
			streak_q      <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (upd) begin
				state_q  <= state_n;
				reason_q <= reason_n;
				since_q  <= since_n;
				term_q   <= term_n;
				leader_q <= leader_n;
				latch_q  <= latch_n;
				gmark_q  <= gmark_n;
				streak_q <= streak_n;
			end
			if (adv) begin
				m_axis_tvalid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			m_axis_tdata <= {5'd0, open_n, gmark_n, latch_n, leader_n, term_n,
				since_n, reason_n, state_n};
		end
	end

endmodule

>>> rtl/leader_health_state_machine_top.sv
// ----------------------------------------------------------------------------
// leader_health_state_machine_top
// Leader health supervisor: role commands and probe reports in, one status out.
// ----------------------------------------------------------------------------
// Each input transfer carries a command on s_axis_tuser (enter follower, enter
// leader grace, probe report); command 3 changes nothing and still gives a
// result. Every input transfer yields exactly one output transfer with the
// state after the item, the reason for it, the time the state was entered,
// the stored term, the leader, latch and grace flags, and whether the grace
// window is open at the item's own time. Each item passes the input register,
// then the result register; one item is taken per cycle while the output
// is not held back, the rate being set by the update of the supervisor state
// from the input register into the result register. A result waiting on
// m_axis_tready stalls the input side only while both the input and result
// registers are full.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect on the next
// edge and should only be made while the block is idle; a threshold of zero
// behaves as one.
// ----------------------------------------------------------------------------
module leader_health_state_machine_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: 0 fail_threshold, 1 recover_successes, 2 grace_ms
	input  logic                                cfg_we,
	input  logic [lhsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lhsm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// now_ms[47:0], term[79:48], spaces_failures[87:80],
	// session_failures[95:88], monitor_stalled[96], zero pad
	input  logic [lhsm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// command[1:0]
	input  logic [lhsm_pkg::CMD_W-1:0]          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// health_state[2:0], reason_code[6:3], since_ms[54:7], term_out[86:55],
	// is_leader[87], latched[88], grace_flag[89], in_grace[90], zero pad
	output logic [lhsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	lhsm_pkg::cfg_t  cfg;
	lhsm_pkg::item_t item_s1;
	logic            valid_s1;
	logic            adv;

	// effective thresholds, precomputed at write time
	lhsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register; frees as soon as the update stage can take its item
	lhsm_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.adv           (adv),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	// state update and result register
	lhsm_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
